### sv/pabc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pabc_pkg: shared types and constants for the particle advect/blend/clamp unit
// Transaction payloads, configuration bundle, lane interface and fixed-point
// constants (all positions and velocities are signed Q16.16).
// ----------------------------------------------------------------------------
package pabc_pkg;

  // Input transaction
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] grid_vel_x;
    logic signed [31:0] grid_vel_y;
    logic signed [31:0] delta_vel_x;
    logic signed [31:0] delta_vel_y;
    logic               is_active;
    logic               last_in;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               still_active;
    logic               last_out;
  } out_item_t;

  // Configuration register bundle
  typedef struct packed {
    logic        [31:0] time_step;
    logic signed [15:0] blend_ratio;
    logic        [30:0] period_x;
    logic signed [31:0] bound_min_x;
    logic signed [31:0] bound_min_y;
    logic signed [31:0] bound_max_x;
    logic signed [31:0] bound_max_y;
    logic        [3:0]  mode_flags;
  } cfg_t;

  // Register indexes on the write port
  typedef enum logic [2:0] {
    CfgTimeStep  = 3'd0,
    CfgBlend     = 3'd1,
    CfgPeriodX   = 3'd2,
    CfgBoundMinX = 3'd3,
    CfgBoundMinY = 3'd4,
    CfgBoundMaxX = 3'd5,
    CfgBoundMaxY = 3'd6,
    CfgModeFlags = 3'd7
  } cfg_idx_e;

  // Bit positions in mode_flags
  localparam int unsigned ModeHold     = 0;
  localparam int unsigned ModePeriodic = 1;
  localparam int unsigned ModeReloc    = 2;
  localparam int unsigned ModeBounds   = 3;

  // Reset values
  localparam logic        [31:0] TimeStepRst  = 32'd0;
  localparam logic signed [15:0] BlendRst     = 16'sd3891;
  localparam logic        [30:0] PeriodXRst   = 31'd65536;
  localparam logic signed [31:0] BoundMinRst  = 32'sd0;
  localparam logic signed [31:0] BoundMaxRst  = 32'sd65536;
  localparam logic        [3:0]  ModeRst      = 4'd0;

  // Blend constants (Q4.12)
  localparam logic signed [15:0] BlendApicLim = -16'sd4096;
  localparam logic signed [17:0] OneQ12       = 18'sd4096;
  localparam logic signed [50:0] HalfQ12      = 51'sd2048;
  // Half an LSB of Q16.16 when the product is Q16.48
  localparam logic signed [65:0] HalfQ48      = 66'sd2147483648;

  // Relocation constants (Q16.16): trigger 0.8, new x -0.1, y offset 0.27
  localparam logic signed [32:0] RelocTrigger = 33'sd52429;
  localparam logic signed [31:0] RelocX       = -32'sd6554;
  localparam logic signed [32:0] RelocDy      = 33'sd17695;
  localparam logic signed [31:0] S32Max       = 32'sh7fff_ffff;

  // One coordinate's worth of input for a lane
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] pic;
    logic signed [31:0] inc;
  } lane_in_t;

  // Lane result after advection and blending
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               act;
    logic               bad;
  } lane_out_t;

endpackage

### sv/particle_advect_blend_clamp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_advect_blend_clamp_unit: PIC/FLIP particle update, Q16.16
// Advects one 2D particle per transaction, blends its velocity and applies
// overflow, periodic, floor, relocation and bounds handling.
// ----------------------------------------------------------------------------
// One particle transaction is accepted every clock cycle unless the input
// stalls; it passes through two stages in each coordinate lane (multiply,
// then round/accumulate) and two merge stages (overflow/wrap/floor, then
// relocation/clamp). Throughput is one transaction per cycle while the
// output is not stalled, set by the per-lane multipliers which are fully
// pipelined. Back-pressure on the output only stalls the input once every
// stage holds a transaction. Configuration registers are written directly and
// must only change while no transaction is in flight; there is no read-back.
// ----------------------------------------------------------------------------
module particle_advect_blend_clamp_unit import pabc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  // ---- configuration registers ----
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step   <= TimeStepRst;
      cfg_q.blend_ratio <= BlendRst;
      cfg_q.period_x    <= PeriodXRst;
      cfg_q.bound_min_x <= BoundMinRst;
      cfg_q.bound_min_y <= BoundMinRst;
      cfg_q.bound_max_x <= BoundMaxRst;
      cfg_q.bound_max_y <= BoundMaxRst;
      cfg_q.mode_flags  <= ModeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTimeStep:  cfg_q.time_step   <= cfg_wdata_i;
        CfgBlend:     cfg_q.blend_ratio <= cfg_wdata_i[15:0];
        CfgPeriodX:   cfg_q.period_x    <= cfg_wdata_i[30:0];
        CfgBoundMinX: cfg_q.bound_min_x <= cfg_wdata_i;
        CfgBoundMinY: cfg_q.bound_min_y <= cfg_wdata_i;
        CfgBoundMaxX: cfg_q.bound_max_x <= cfg_wdata_i;
        CfgBoundMaxY: cfg_q.bound_max_y <= cfg_wdata_i;
        CfgModeFlags: cfg_q.mode_flags  <= cfg_wdata_i[3:0];
        default:      ;
      endcase
    end
  end

  // ---- pipeline occupancy and flow control ----
  // A stage may load when it is empty or the stage after it moves on.
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;
  logic en1, en2, en3, en4;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // Payload registers only load on an incoming transaction
  assign en1 = rdy1 && in_valid_i;
  assign en2 = rdy2 && v1_q;
  assign en3 = rdy3 && v2_q;
  assign en4 = rdy4 && v3_q;

  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? v1_q       : v2_q;
  assign v3_d = rdy3 ? v2_q       : v3_q;
  assign v4_d = rdy4 ? v3_q       : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

  // ---- sweep marker rides alongside the lane stages ----
  logic last1_q, last2_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      last1_q <= in_data_i.last_in;
    end
    if (en2) begin
      last2_q <= last1_q;
    end
  end

  // ---- coordinate lanes ----
  lane_in_t  lane_x_in, lane_y_in;
  lane_out_t lane_x_out, lane_y_out;

  assign lane_x_in.pos = in_data_i.pos_x;
  assign lane_x_in.vel = in_data_i.vel_x;
  assign lane_x_in.pic = in_data_i.grid_vel_x;
  assign lane_x_in.inc = in_data_i.delta_vel_x;
  assign lane_y_in.pos = in_data_i.pos_y;
  assign lane_y_in.vel = in_data_i.vel_y;
  assign lane_y_in.pic = in_data_i.grid_vel_y;
  assign lane_y_in.inc = in_data_i.delta_vel_y;

  pabc_lane u_lane_x (
    .clk_i    (clk_i),
    .en1_i    (en1),
    .en2_i    (en2),
    .active_i (in_data_i.is_active),
    .lane_i   (lane_x_in),
    .cfg_i    (cfg_q),
    .lane_o   (lane_x_out)
  );

  pabc_lane u_lane_y (
    .clk_i    (clk_i),
    .en1_i    (en1),
    .en2_i    (en2),
    .active_i (in_data_i.is_active),
    .lane_i   (lane_y_in),
    .cfg_i    (cfg_q),
    .lane_o   (lane_y_out)
  );

  // ---- merge: overflow handling, wrap, floor, relocation, clamp ----
  // Its final register is the output register.
  pabc_merge u_merge (
    .clk_i    (clk_i),
    .en3_i    (en3),
    .en4_i    (en4),
    .last_i   (last2_q),
    .lane_x_i (lane_x_out),
    .lane_y_i (lane_y_out),
    .cfg_i    (cfg_q),
    .out_o    (out_data_o)
  );

endmodule

### sv/pabc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pabc_lane: per-coordinate advection and velocity blend
// Stage 1 forms the three products, stage 2 rounds, sums and range checks.
// ----------------------------------------------------------------------------
module pabc_lane import pabc_pkg::*; (
  input  logic      clk_i,
  input  logic      en1_i,
  input  logic      en2_i,
  input  logic      active_i,
  input  lane_in_t  lane_i,
  input  cfg_t      cfg_i,
  output lane_out_t lane_o
);

  // ---- stage 1: multipliers ----
  logic        [15:0] a_mag;
  logic signed [32:0] vsum;
  logic signed [16:0] coef_a;
  logic signed [17:0] coef_b;
  logic signed [64:0] prod_p;
  logic signed [49:0] prod_a;
  logic signed [49:0] prod_b;

  assign a_mag  = cfg_i.blend_ratio[15] ? (~cfg_i.blend_ratio + 16'd1) : cfg_i.blend_ratio;
  assign vsum   = $signed({lane_i.vel[31], lane_i.vel}) + $signed({lane_i.inc[31], lane_i.inc});
  assign coef_a = $signed({1'b0, a_mag});
  assign coef_b = OneQ12 - $signed({2'b00, a_mag});
  assign prod_p = $signed(lane_i.pic) * $signed({1'b0, cfg_i.time_step});
  assign prod_a = vsum * coef_a;
  assign prod_b = $signed(lane_i.pic) * coef_b;

  logic               s1_act_q;
  logic signed [31:0] s1_pos_q;
  logic signed [31:0] s1_vel_q;
  logic signed [31:0] s1_pic_q;
  logic signed [64:0] s1_prodp_q;
  logic signed [49:0] s1_proda_q;
  logic signed [49:0] s1_prodb_q;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      s1_act_q   <= active_i;
      s1_pos_q   <= lane_i.pos;
      s1_vel_q   <= lane_i.vel;
      s1_pic_q   <= lane_i.pic;
      s1_prodp_q <= prod_p;
      s1_proda_q <= prod_a;
      s1_prodb_q <= prod_b;
    end
  end

  // ---- stage 2: round, accumulate, range check ----
  logic signed [65:0] p_rnd;
  logic signed [33:0] step;
  logic signed [34:0] pos_sum;
  logic signed [50:0] acc;
  logic signed [38:0] vblend;
  logic               pos_ok;
  logic               vel_ok;
  logic               hold;
  logic               apic;
  lane_out_t          lane_d;
  lane_out_t          lane_q;

  assign p_rnd   = $signed({s1_prodp_q[64], s1_prodp_q}) + HalfQ48;
  assign step    = p_rnd[65:32];
  assign pos_sum = $signed({{3{s1_pos_q[31]}}, s1_pos_q}) + $signed({step[33], step});
  assign acc     = $signed({s1_proda_q[49], s1_proda_q})
                 + $signed({s1_prodb_q[49], s1_prodb_q}) + HalfQ12;
  assign vblend  = acc[50:12];
  assign hold    = cfg_i.mode_flags[ModeHold];
  assign apic    = cfg_i.blend_ratio < BlendApicLim;
  assign pos_ok  = (&pos_sum[34:31]) | ~(|pos_sum[34:31]);

  always_comb begin
    lane_d     = '0;
    lane_d.act = s1_act_q;
    vel_ok     = 1'b1;
    if (!s1_act_q) begin
      lane_d.pos = s1_pos_q;
      lane_d.vel = s1_vel_q;
    end else begin
      lane_d.pos = pos_sum[31:0];
      if (hold) begin
        lane_d.vel = s1_vel_q;
      end else if (apic) begin
        lane_d.vel = s1_pic_q;
      end else begin
        lane_d.vel = vblend[31:0];
        vel_ok     = (&vblend[38:31]) | ~(|vblend[38:31]);
      end
      lane_d.bad = !(pos_ok && vel_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

### sv/pabc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pabc_merge: combines both lanes and applies the boundary handling
// Stage 3: overflow reset, periodic wrap, floor. Stage 4: relocation, clamp.
// ----------------------------------------------------------------------------
module pabc_merge import pabc_pkg::*; (
  input  logic      clk_i,
  input  logic      en3_i,
  input  logic      en4_i,
  input  logic      last_i,
  input  lane_out_t lane_x_i,
  input  lane_out_t lane_y_i,
  input  cfg_t      cfg_i,
  output out_item_t out_o
);

  // ---- stage 3 ----
  logic               use_b;
  logic signed [32:0] x33;
  logic signed [32:0] lx;
  logic signed [31:0] px_d, py_d, vx_d, vy_d;
  logic               act_d, live_d;

  assign use_b = cfg_i.mode_flags[ModeBounds];
  assign x33   = $signed({lane_x_i.pos[31], lane_x_i.pos});
  assign lx    = $signed({2'b00, cfg_i.period_x});

  always_comb begin
    px_d   = lane_x_i.pos;
    py_d   = lane_y_i.pos;
    vx_d   = lane_x_i.vel;
    vy_d   = lane_y_i.vel;
    act_d  = lane_x_i.act;
    live_d = 1'b0;
    if (lane_x_i.act) begin
      if (lane_x_i.bad || lane_y_i.bad) begin
        // NaN/Inf stand-in: park the particle
        act_d = 1'b0;
        vx_d  = '0;
        vy_d  = '0;
        px_d  = use_b ? cfg_i.bound_min_x : '0;
        py_d  = use_b ? cfg_i.bound_min_y : '0;
      end else begin
        live_d = 1'b1;
        if (cfg_i.mode_flags[ModePeriodic]) begin
          if (x33 > lx) begin
            px_d = 32'(x33 - lx);
          end else if (x33 < 33'sd0) begin
            px_d = 32'(x33 + lx);
          end
        end
        if (lane_y_i.pos < 32'sd0) begin
          py_d = '0;
          if (lane_y_i.vel < 32'sd0) begin
            vy_d = '0;
          end
        end
      end
    end
  end

  logic signed [31:0] s3_px_q, s3_py_q, s3_vx_q, s3_vy_q;
  logic               s3_act_q, s3_live_q, s3_last_q;

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      s3_px_q   <= px_d;
      s3_py_q   <= py_d;
      s3_vx_q   <= vx_d;
      s3_vy_q   <= vy_d;
      s3_act_q  <= act_d;
      s3_live_q <= live_d;
      s3_last_q <= last_i;
    end
  end

  // ---- stage 4 ----
  logic signed [32:0] y_off;
  logic signed [31:0] rx, ry;
  out_item_t          out_d;
  out_item_t          out_q;
  logic               clamped;

  assign y_off = $signed({s3_py_q[31], s3_py_q}) + RelocDy;

  always_comb begin
    rx      = s3_px_q;
    ry      = s3_py_q;
    clamped = 1'b0;
    out_d   = '0;
    out_d.new_vel_x    = s3_vx_q;
    out_d.new_vel_y    = s3_vy_q;
    out_d.still_active = s3_act_q;
    out_d.last_out     = s3_last_q;
    if (s3_live_q) begin
      if (cfg_i.mode_flags[ModeReloc] &&
          ($signed({s3_px_q[31], s3_px_q}) > RelocTrigger)) begin
        rx = RelocX;
        ry = (y_off[32] != y_off[31]) ? S32Max : y_off[31:0];
      end
      if (use_b) begin
        if (rx < cfg_i.bound_min_x) begin
          rx      = cfg_i.bound_min_x;
          clamped = 1'b1;
        end else if (rx > cfg_i.bound_max_x) begin
          rx      = cfg_i.bound_max_x;
          clamped = 1'b1;
        end
        if (ry < cfg_i.bound_min_y) begin
          ry      = cfg_i.bound_min_y;
          clamped = 1'b1;
        end else if (ry > cfg_i.bound_max_y) begin
          ry      = cfg_i.bound_max_y;
          clamped = 1'b1;
        end
      end
      if (clamped) begin
        out_d.new_vel_x    = '0;
        out_d.new_vel_y    = '0;
        out_d.still_active = 1'b0;
      end
    end
    out_d.new_pos_x = rx;
    out_d.new_pos_y = ry;
  end

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for particle_advect_blend_clamp_unit
// Sends particle transactions through the unit under random idling and
// back-pressure. Each result is checked against an in-bench Q16.16 model of
// the PIC/FLIP update. Directed tests come first, then random streams.
// ----------------------------------------------------------------------------
module tb_top;
  import pabc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  // Idle cycles allowed after the last owed result before a register write
  localparam int DRAIN_CYCLES   = 8;
  // Cycles with no transaction on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;

  // Fixed-point constants of the update
  localparam longint HALF_LSB_Q48  = 64'sh8000_0000;  // rounding for dt*pic
  localparam longint ONE_Q12       = 4096;
  localparam longint HALF_Q12      = 2048;
  localparam longint S32_HI        = 64'sh7FFF_FFFF;
  localparam longint S32_LO        = -64'sh8000_0000;
  localparam longint RELOC_TRIGGER = 52429;            // 0.8
  localparam longint RELOC_X       = -6554;            // -0.1
  localparam longint RELOC_DY      = 17695;            // 0.27

  localparam cfg_t CFG_RESET = '{
    time_step:   TimeStepRst,
    blend_ratio: BlendRst,
    period_x:    PeriodXRst,
    bound_min_x: BoundMinRst,
    bound_min_y: BoundMinRst,
    bound_max_x: BoundMaxRst,
    bound_max_y: BoundMaxRst,
    mode_flags:  ModeRst
  };

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  cfg_idx_e    cfg_idx   = CfgTimeStep;
  logic [31:0] cfg_wdata = '0;

  // Register contents as the unit should hold them
  cfg_t        unit_cfg  = CFG_RESET;
  // Updated particles still owed by the unit, oldest first
  out_item_t   pending_updates [$];

  int error_count   = 0;
  int stuck_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;

  particle_advect_blend_clamp_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Particle update model: advection, blend, overflow, wrap, floor,
  // relocation and bounds clamp, all at 64 bits so no range is lost.
  // --------------------------------------------------------------------------
  function automatic out_item_t advance_particle(input in_item_t p);
    out_item_t r;
    longint    pos [2];
    longint    vel [2];
    longint    pic [2];
    longint    inc [2];
    longint    bmin [2];
    longint    bmax [2];
    longint    dt, ratio, a, acc, period;
    logic      act, bad, use_bounds;
    int        d;

    dt      = unit_cfg.time_step;
    ratio   = $signed(unit_cfg.blend_ratio);
    period  = unit_cfg.period_x;
    bmin[0] = $signed(unit_cfg.bound_min_x);
    bmin[1] = $signed(unit_cfg.bound_min_y);
    bmax[0] = $signed(unit_cfg.bound_max_x);
    bmax[1] = $signed(unit_cfg.bound_max_y);
    use_bounds = unit_cfg.mode_flags[ModeBounds];

    pos[0] = $signed(p.pos_x);       pos[1] = $signed(p.pos_y);
    vel[0] = $signed(p.vel_x);       vel[1] = $signed(p.vel_y);
    pic[0] = $signed(p.grid_vel_x);  pic[1] = $signed(p.grid_vel_y);
    inc[0] = $signed(p.delta_vel_x); inc[1] = $signed(p.delta_vel_y);
    act = p.is_active;
    bad = 1'b0;

    if (act) begin
      // dt*pic is Q16.48; round half up back to Q16.16
      for (d = 0; d < 2; d++) begin
        pos[d] += (pic[d] * dt + HALF_LSB_Q48) >>> 32;
      end

      if (!unit_cfg.mode_flags[ModeHold]) begin
        for (d = 0; d < 2; d++) begin
          if (ratio < -ONE_Q12) begin
            vel[d] = pic[d];  // APIC
          end else begin
            // AFLIP uses |r|, PIC/FLIP uses r as given
            a      = (ratio < 0) ? -ratio : ratio;
            acc    = a * (vel[d] + inc[d]) + (ONE_Q12 - a) * pic[d];
            vel[d] = (acc + HALF_Q12) >>> 12;
          end
        end
      end

      for (d = 0; d < 2; d++) begin
        if (pos[d] > S32_HI || pos[d] < S32_LO || vel[d] > S32_HI || vel[d] < S32_LO) begin
          bad = 1'b1;
        end
      end

      if (bad) begin
        // NaN/Inf stand-in: kill the particle, nothing further applies
        act = 1'b0;
        for (d = 0; d < 2; d++) begin
          vel[d] = 0;
          pos[d] = use_bounds ? bmin[d] : 0;
        end
      end else begin
        if (unit_cfg.mode_flags[ModePeriodic]) begin
          if (pos[0] > period) begin
            pos[0] -= period;
          end else if (pos[0] < 0) begin
            pos[0] += period;
          end
        end
        if (pos[1] < 0) begin
          pos[1] = 0;
          if (vel[1] < 0) begin
            vel[1] = 0;
          end
        end
        if (unit_cfg.mode_flags[ModeReloc] && pos[0] > RELOC_TRIGGER) begin
          pos[0] = RELOC_X;
          pos[1] += RELOC_DY;
          if (pos[1] > S32_HI) begin
            pos[1] = S32_HI;
          end
        end
        if (use_bounds) begin
          // min test first, so it wins when the limits cross
          for (d = 0; d < 2; d++) begin
            if (pos[d] < bmin[d]) begin
              pos[d] = bmin[d];
              act    = 1'b0;
            end else if (pos[d] > bmax[d]) begin
              pos[d] = bmax[d];
              act    = 1'b0;
            end
          end
          if (!act) begin
            vel[0] = 0;
            vel[1] = 0;
          end
        end
      end
    end

    r.new_pos_x    = pos[0][31:0];
    r.new_pos_y    = pos[1][31:0];
    r.new_vel_x    = vel[0][31:0];
    r.new_vel_y    = vel[1][31:0];
    r.still_active = act;
    r.last_out     = p.last_in;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t particle(
    input logic [31:0] px, py, vx, vy, gx, gy, dx, dy,
    input logic        act, last
  );
    in_item_t p;
    p.pos_x       = px;  p.pos_y       = py;
    p.vel_x       = vx;  p.vel_y       = vy;
    p.grid_vel_x  = gx;  p.grid_vel_y  = gy;
    p.delta_vel_x = dx;  p.delta_vel_y = dy;
    p.is_active   = act;
    p.last_in     = last;
    return p;
  endfunction

  // Mostly values around the unit domain, now and then any 32-bit pattern
  function automatic logic [31:0] rand_q16(input int unsigned span);
    if ($urandom_range(7) == 0) begin
      return $urandom;
    end
    return 32'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  function automatic in_item_t random_particle();
    return particle(rand_q16(32'h2_0000), rand_q16(32'h2_0000),
                    rand_q16(32'h4_0000), rand_q16(32'h4_0000),
                    rand_q16(32'h4_0000), rand_q16(32'h4_0000),
                    rand_q16(32'h1_0000), rand_q16(32'h1_0000),
                    $urandom_range(7) != 0, $urandom_range(15) == 0);
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    case ($urandom_range(3))
      0:       c.time_step = '0;
      1:       c.time_step = '1;
      2:       c.time_step = $urandom_range(32'h1000_0000);
      default: c.time_step = $urandom;
    endcase
    // APIC, AFLIP or PIC/FLIP region, PIC/FLIP the most common
    case ($urandom_range(3))
      0:       c.blend_ratio = 16'(int'($urandom_range(28671)) - 32768);
      1:       c.blend_ratio = 16'(-int'($urandom_range(4096, 1)));
      default: c.blend_ratio = 16'($urandom_range(4096));
    endcase
    case ($urandom_range(4))
      0:       c.period_x = '0;
      1:       c.period_x = '1;
      2:       c.period_x = 31'($urandom);
      default: c.period_x = 31'($urandom_range(32'h2_0000));
    endcase
    if ($urandom_range(4) == 0) begin
      c.bound_min_x = $urandom;
      c.bound_min_y = $urandom;
      c.bound_max_x = $urandom;
      c.bound_max_y = $urandom;
    end else begin
      c.bound_min_x = 32'(-int'($urandom_range(32'h8000)));
      c.bound_min_y = 32'(-int'($urandom_range(32'h8000)));
      c.bound_max_x = 32'(int'($urandom_range(32'h1_8000, 32'h8000)));
      c.bound_max_y = 32'(int'($urandom_range(32'h1_8000, 32'h8000)));
    end
    c.mode_flags = 4'($urandom_range(15));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Offer one particle transaction; returns at the edge that accepts it
  task automatic send_particle(input in_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    pending_updates.push_back(advance_particle(p));
  endtask

  // Stop offering and let every owed result come out
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers, one per cycle, once the unit is empty
  task automatic load_config(input cfg_t c);
    logic [31:0] word [8];
    cfg_idx_e    idx;

    wait_for_quiet();
    word[CfgTimeStep]  = c.time_step;
    word[CfgBlend]     = 32'(c.blend_ratio);
    word[CfgPeriodX]   = {1'b0, c.period_x};
    word[CfgBoundMinX] = c.bound_min_x;
    word[CfgBoundMinY] = c.bound_min_y;
    word[CfgBoundMaxX] = c.bound_max_x;
    word[CfgBoundMaxY] = c.bound_max_y;
    word[CfgModeFlags] = {28'd0, c.mode_flags};
    idx = idx.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= word[idx];
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we   <= 1'b0;
    unit_cfg = c;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req <= 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checking against the oldest owed update
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %08h, got %08h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        $error("result transaction with no particle owed");
        error_count++;
      end else begin
        want = pending_updates.pop_front();
        check_field("new_pos_x",    want.new_pos_x,    out_data.new_pos_x);
        check_field("new_pos_y",    want.new_pos_y,    out_data.new_pos_y);
        check_field("new_vel_x",    want.new_vel_x,    out_data.new_vel_x);
        check_field("new_vel_y",    want.new_vel_y,    out_data.new_vel_y);
        check_field("still_active", want.still_active, out_data.still_active);
        check_field("last_out",     want.last_out,     out_data.last_out);
      end
    end
  end

  // Watchdog: too long with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Register values straight out of reset: dt of zero, ratio about 0.95
  task automatic test_reset_values();
    send_particle(particle(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, -32'sh1_0000,
                           32'h0002_0000, 32'h0000_4000, 32'h0000_0100, -32'sh100,
                           1'b1, 1'b0));
  endtask

  // Inactive particles come back untouched, whatever the settings
  task automatic test_inactive_passthrough();
    cfg_t c;
    c = CFG_RESET;
    c.time_step  = '1;
    c.mode_flags = '1;
    load_config(c);
    send_particle(particle('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1,
                           '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, 1'b0, 1'b1));
    send_particle(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           1'b0, 1'b0));
  endtask

  task automatic blend_case(input logic signed [15:0] ratio, input logic hold);
    cfg_t c;
    c = CFG_RESET;
    c.time_step   = 32'h8000_0000;  // dt = 0.5
    c.blend_ratio = ratio;
    c.mode_flags[ModeHold] = hold;
    load_config(c);
    send_particle(particle(32'h0000_4000, 32'h0000_8000, 32'h0001_0000, -32'sh8000,
                           32'h0002_0000, -32'sh3_0000, 32'h0000_1800, 32'h0000_2400,
                           1'b1, 1'b0));
  endtask

  // Each blend region and its edges, plus velocity hold
  task automatic test_blend_modes();
    blend_case(BlendRst, 1'b0);
    blend_case(16'sd4096, 1'b0);
    blend_case(16'sd0, 1'b0);
    blend_case(-16'sd1, 1'b0);
    blend_case(-16'sd4096, 1'b0);
    blend_case(-16'sd4097, 1'b0);
    blend_case(16'sh8000, 1'b0);
    blend_case(BlendRst, 1'b1);
  endtask

  // Positions and velocities leaving the 32-bit range
  task automatic test_overflow();
    cfg_t c;
    c = CFG_RESET;
    c.time_step = '1;
    load_config(c);
    send_particle(particle(32'h7FFF_0000, 32'h8000_0000, 32'h0000_1000, 32'h0000_1000,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b0));
    // with the bounds clamp on, the position goes to the lower limits
    c.mode_flags[ModeBounds] = 1'b1;
    c.bound_min_x = -32'sd5;
    c.bound_min_y = 32'sd7;
    load_config(c);
    send_particle(particle(32'h7FFF_0000, 32'h8000_0000, 32'h0000_1000, 32'h0000_1000,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b1));
    // velocity alone overflowing
    c.time_step   = '0;
    c.blend_ratio = 16'sd4096;
    load_config(c);
    send_particle(particle(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
                           32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0));
  endtask

  // Periodic x wrap, floor at y=0 and the fixed relocation
  task automatic test_wrap_floor_reloc();
    cfg_t c;
    c = CFG_RESET;
    c.mode_flags[ModeHold]     = 1'b1;
    c.mode_flags[ModePeriodic] = 1'b1;
    load_config(c);
    send_particle(particle(32'd70000, 32'd100, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b0));
    send_particle(particle(-32'sd100, 32'd100, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b0));
    send_particle(particle(32'd100, -32'sd5, 32'd5, -32'sd3, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b0));
    send_particle(particle(32'd100, -32'sd5, 32'd5, 32'sd3, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b0));
    c.mode_flags[ModeReloc] = 1'b1;
    load_config(c);
    send_particle(particle(32'd60000, 32'd1000, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b0));
    // the y shift saturates near the top of the range
    send_particle(particle(32'd60000, 32'h7FFF_F000, 32'd5, 32'd5, 32'd0, 32'd0,
                           32'd0, 32'd0, 1'b1, 1'b0));
    // exactly on the trigger does not relocate
    send_particle(particle(32'd52429, 32'd1000, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b1));
  endtask

  // Bounds clamp, crossed limits and the widest limits
  task automatic test_bounds_clamp();
    cfg_t c;
    c = CFG_RESET;
    c.mode_flags[ModeHold]   = 1'b1;
    c.mode_flags[ModeBounds] = 1'b1;
    load_config(c);
    send_particle(particle(-32'sd1, 32'd100, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b0));
    send_particle(particle(32'd100, 32'd70000, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b0));
    send_particle(particle(32'd100, 32'd100, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b0));
    c.bound_min_x = 32'sd100;
    c.bound_max_x = -32'sd100;
    load_config(c);
    send_particle(particle(32'd0, 32'd100, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0,
                           1'b1, 1'b0));
    c.bound_min_x = 32'sh8000_0000;
    c.bound_min_y = 32'sh8000_0000;
    c.bound_max_x = 32'sh7FFF_FFFF;
    c.bound_max_y = 32'sh7FFF_FFFF;
    c.period_x    = '1;
    load_config(c);
    send_particle(particle(32'h8000_0000, 32'h7FFF_FFFF, 32'd5, 32'd5, 32'd0, 32'd0,
                           32'd0, 32'd0, 1'b1, 1'b1));
  endtask

  // Long receiver hold-off while the sender keeps offering, so the
  // pipeline fills and stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config(random_config());
    hold_req <= 80;
    repeat (24) send_particle(random_particle());
    wait_for_quiet();
  endtask

  task automatic test_random_stream(input int send_pct, recv_pct, n_sets, n_items);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_sets) begin
      load_config(random_config());
      repeat (n_items) send_particle(random_particle());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_inactive_passthrough();
    test_blend_modes();
    test_overflow();
    test_wrap_floor_reloc();
    test_bounds_clamp();
    test_backpressure();
    test_random_stream(38, 64, 4, 38);
    test_random_stream(64, 38, 4, 38);
    test_random_stream(0, 0, 4, 38);

    wait_for_quiet();
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/pabc_pkg.sv
sv/pabc_lane.sv
sv/pabc_merge.sv
sv/particle_advect_blend_clamp_unit.sv
test/tb_top.sv
